>>> sv/rcvc_pkg.sv
// ----------------------------------------------------------------------------
// rcvc_pkg - shared definitions of the rate-controlled virtual clock
// Field widths, command, run state and error codes, and the request and
// result structs between the command sequencer and the arithmetic engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rcvc_pkg;

    localparam int RATE_SCALE_DEFAULT = 1000;

    localparam int TIME_W  = 64;
    localparam int RATE_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int STATE_W = 2;
    localparam int ERR_W   = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_TIME  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_RATE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESUME    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TERMINATE = 3'd5;

    // run states
    localparam logic [STATE_W-1:0] ST_RUNNING = 2'd0;
    localparam logic [STATE_W-1:0] ST_PAUSED  = 2'd1;
    localparam logic [STATE_W-1:0] ST_STOPPED = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ORDER = 2'd2;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] real_now;
        logic [TIME_W-1:0] real_origin;
        logic [TIME_W-1:0] virtual_origin;
        logic [TIME_W-1:0] time_limit;
        logic [RATE_W-1:0] rate;
    } rcvc_calc_req_t;

    typedef struct packed {
        logic              done;
        logic              fail;
        logic [TIME_W-1:0] vtime;
    } rcvc_calc_res_t;

endpackage

`default_nettype wire

>>> sv/rcvc_engine.sv
// ----------------------------------------------------------------------------
// rcvc_engine - serial virtual time calculator
// Derives the virtual time at a given real time with a bit-serial divider by
// the rate scale and two shift-add multipliers for the range check, the second
// of which is reused for the scaled product.
// ----------------------------------------------------------------------------
`default_nettype none

module rcvc_engine #(
    parameter int RATE_SCALE = rcvc_pkg::RATE_SCALE_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rcvc_pkg::rcvc_calc_req_t req,
    output rcvc_pkg::rcvc_calc_res_t     res
);

    localparam int TW      = rcvc_pkg::TIME_W;
    localparam int RW      = rcvc_pkg::RATE_W;
    localparam int SCALE_W = $clog2(RATE_SCALE + 1);
    localparam int MULT_W  = (SCALE_W < 2) ? 2 : SCALE_W;
    localparam int P1_W    = TW + MULT_W;
    localparam int P2_W    = TW + RW;
    localparam int CNT_W   = $clog2(TW);

    localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(TW - 1);
    localparam logic [CNT_W-1:0]   MAG_LAST    = CNT_W'(RW - 1);
    localparam logic [CNT_W-1:0]   SCALE_STEPS = CNT_W'(MULT_W);
    localparam logic [SCALE_W:0]   SCALE_TRIAL = (SCALE_W + 1)'(RATE_SCALE);
    localparam logic [MULT_W-1:0]  SCALE_MULT  = MULT_W'(RATE_SCALE);
    localparam logic [RW-1:0]      RATE_ONE    = RW'(RATE_SCALE);

    typedef enum logic [2:0] {
        E_IDLE,
        E_CHECK,
        E_MUL,
        E_CMP,
        E_QMUL,
        E_SUM
    } eng_state_t;

    eng_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic                fail_reg, fail_next;
    logic [TW-1:0]       vtime_reg, vtime_next;

    logic [TW-1:0]       delta_reg, delta_next;
    logic [TW-1:0]       bound_reg, bound_next;
    logic [TW-1:0]       vo_reg, vo_next;
    logic [RW-1:0]       mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                one_reg, one_next;
    logic [TW-1:0]       qd_reg, qd_next;
    logic [SCALE_W-1:0]  rem_reg, rem_next;
    logic [P1_W-1:0]     p1_reg, p1_next;
    logic [P2_W-1:0]     p2_reg, p2_next;

    logic [SCALE_W:0]    trial;
    logic                trial_ge;
    logic [SCALE_W:0]    trial_diff;
    logic [TW:0]         p1_sum;
    logic [TW:0]         p2_sum;
    logic [TW-1:0]       p2_mcand;
    logic                prod_lt;
    logic                req_neg;
    logic [RW-1:0]       req_mag;

    // one quotient bit per cycle; remainder stays below the scale
    assign trial      = {rem_reg, qd_reg[TW-1]};
    assign trial_ge   = (trial >= SCALE_TRIAL);
    assign trial_diff = trial - SCALE_TRIAL;

    // shift-add steps, multiplier bits leave at the bottom
    assign p1_sum   = {1'b0, p1_reg[P1_W-1:MULT_W]} + (p1_reg[0] ? {1'b0, bound_reg} : '0);
    assign p2_mcand = (state_reg == E_QMUL) ? qd_reg : delta_reg;
    assign p2_sum   = {1'b0, p2_reg[P2_W-1:RW]} + (p2_reg[0] ? {1'b0, p2_mcand} : '0);
    assign prod_lt  = ({{(P2_W - P1_W){1'b0}}, p1_reg} < p2_reg);

    assign req_neg = req.rate[RW-1];
    assign req_mag = req_neg ? (~req.rate + RW'(1)) : req.rate;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        fail_next  = fail_reg;
        vtime_next = vtime_reg;
        delta_next = delta_reg;
        bound_next = bound_reg;
        vo_next    = vo_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        one_next   = one_reg;
        qd_next    = qd_reg;
        rem_next   = rem_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;

        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    delta_next = req.real_now - req.real_origin;
                    bound_next = req_neg ? req.virtual_origin
                                         : (req.time_limit - req.virtual_origin);
                    vo_next    = req.virtual_origin;
                    mag_next   = req_mag;
                    neg_next   = req_neg;
                    one_next   = (req.rate == RATE_ONE);
                    state_next = E_CHECK;
                end
            end
            E_CHECK:
            begin
                if (delta_reg > bound_reg)
                begin
                    fail_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else if (one_reg)
                begin
                    fail_next  = 1'b0;
                    vtime_next = vo_reg + delta_reg;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else
                begin
                    qd_next    = delta_reg;
                    rem_next   = '0;
                    p1_next    = {{TW{1'b0}}, SCALE_MULT};
                    p2_next    = {{TW{1'b0}}, mag_reg};
                    cnt_next   = '0;
                    state_next = E_MUL;
                end
            end
            E_MUL:
            begin
                qd_next  = {qd_reg[TW-2:0], trial_ge};
                rem_next = trial_ge ? trial_diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
                if (cnt_reg < SCALE_STEPS)
                begin
                    p1_next = {p1_sum, p1_reg[MULT_W-1:1]};
                end
                if (cnt_reg <= MAG_LAST)
                begin
                    p2_next = {p2_sum, p2_reg[RW-1:1]};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = E_CMP;
                end
            end
            E_CMP:
            begin
                if (prod_lt)
                begin
                    fail_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else
                begin
                    p2_next    = {{TW{1'b0}}, mag_reg};
                    cnt_next   = '0;
                    state_next = E_QMUL;
                end
            end
            E_QMUL:
            begin
                p2_next  = {p2_sum, p2_reg[RW-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == MAG_LAST)
                begin
                    state_next = E_SUM;
                end
            end
            E_SUM:
            begin
                // a negative rate subtracts the magnitude product
                fail_next  = 1'b0;
                vtime_next = neg_reg ? (vo_reg - p2_reg[TW-1:0]) : (vo_reg + p2_reg[TW-1:0]);
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            vtime_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            fail_reg  <= fail_next;
            vtime_reg <= vtime_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        bound_reg <= bound_next;
        vo_reg    <= vo_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        one_reg   <= one_next;
        qd_reg    <= qd_next;
        rem_reg   <= rem_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
    end

    assign res.done  = done_reg;
    assign res.fail  = fail_reg;
    assign res.vtime = vtime_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("engine done held for more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> state_reg == E_IDLE)
        else $error("engine started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_QMUL && $past(state_reg) == E_CMP) |-> cnt_reg == '0)
        else $error("product loop entered with a stale count");
`endif

endmodule

`default_nettype wire

>>> sv/rate_controlled_virtual_clock.sv
// ----------------------------------------------------------------------------
// rate_controlled_virtual_clock - virtual clock scaled from a real time base
// Each request carries a command (func), the current real time and the
// operands of set time and set rate. One result per request returns the
// virtual or frozen time, the rate and run state after the command, and an
// error code. Both channels use valid and stall; a request is taken when
// in_valid is high and in_stall is low, a result when out_valid is high and
// out_stall is low. in_stall rises for the whole time one request is in work.
// Set time, resume, terminate, unused codes, paused or stopped reads and order
// errors go straight to the commit; the other commands launch the engine, which
// answers from its check step at rate one or when the first range check fails,
// else after the 64-step serial divider by RATE_SCALE, the product compare (which
// can fail) and the 32-step shift-add multiplier. One request at a time.
// A stalled result is held in the output register; the next request is taken
// meanwhile and waits for that register to free before it commits.
// time_limit is written over the cfg channel (always ready); write it only while idle, the block does not enforce this.
// Reset: time_limit all ones, origins and frozen time zero, rate one,
// running, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_controlled_virtual_clock #(
    parameter int RATE_SCALE = rcvc_pkg::RATE_SCALE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [rcvc_pkg::FUNC_W-1:0]         func,
    input  wire logic [rcvc_pkg::TIME_W-1:0]         real_now,
    input  wire logic [rcvc_pkg::TIME_W-1:0]         new_time,
    input  wire logic signed [rcvc_pkg::RATE_W-1:0]  new_rate,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [rcvc_pkg::TIME_W-1:0]              time_out,
    output logic signed [rcvc_pkg::RATE_W-1:0]       rate_out,
    output logic [rcvc_pkg::STATE_W-1:0]             run_state_out,
    output logic [rcvc_pkg::ERR_W-1:0]               error_code,
    // time limit register write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rcvc_pkg::TIME_W-1:0]         cfg_data
);

    localparam int TW = rcvc_pkg::TIME_W;
    localparam int RW = rcvc_pkg::RATE_W;
    localparam int SW = rcvc_pkg::STATE_W;
    localparam int EW = rcvc_pkg::ERR_W;
    localparam int FW = rcvc_pkg::FUNC_W;

    typedef enum logic [1:0] {
        T_IDLE,
        T_LAUNCH,
        T_WAIT,
        T_FINISH
    } top_state_t;

    top_state_t        state_reg, state_next;

    // clock state
    logic [TW-1:0]     time_limit_reg, time_limit_next;
    logic [TW-1:0]     real_origin_reg, real_origin_next;
    logic [TW-1:0]     virtual_origin_reg, virtual_origin_next;
    logic [RW-1:0]     rate_reg, rate_next;
    logic [SW-1:0]     run_state_reg, run_state_next;
    logic [TW-1:0]     frozen_time_reg, frozen_time_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [TW-1:0]     time_out_reg, time_out_next;
    logic [RW-1:0]     rate_out_reg, rate_out_next;
    logic [SW-1:0]     run_state_out_reg, run_state_out_next;
    logic [EW-1:0]     error_code_reg, error_code_next;

    // captured request and engine result
    logic [FW-1:0]     func_reg;
    logic [TW-1:0]     now_reg;
    logic [TW-1:0]     newt_reg;
    logic [RW-1:0]     newr_reg;
    logic              calc_fail_reg;
    logic [TW-1:0]     calc_time_reg;

    logic              in_fire;
    logic              need_calc;
    logic              commit;

    rcvc_pkg::rcvc_calc_req_t eng_req;
    rcvc_pkg::rcvc_calc_res_t eng_res;

    assign in_stall  = (state_reg != T_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // a virtual time is needed only for a running read, set rate and a running pause
    assign need_calc = ((func == rcvc_pkg::FUNC_READ) && (run_state_reg == rcvc_pkg::ST_RUNNING))
                    || (func == rcvc_pkg::FUNC_SET_RATE)
                    || ((func == rcvc_pkg::FUNC_PAUSE) && (run_state_reg == rcvc_pkg::ST_RUNNING));

    // commit once the result register is free or being emptied
    assign commit = (state_reg == T_FINISH) && (!out_valid_reg || !out_stall);

    assign eng_req.start          = (state_reg == T_LAUNCH);
    assign eng_req.real_now       = now_reg;
    assign eng_req.real_origin    = real_origin_reg;
    assign eng_req.virtual_origin = virtual_origin_reg;
    assign eng_req.time_limit     = time_limit_reg;
    assign eng_req.rate           = rate_reg;

    rcvc_engine #(
        .RATE_SCALE (RATE_SCALE)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .res   (eng_res)
    );

    always_comb
    begin
        state_next          = state_reg;
        time_limit_next     = time_limit_reg;
        real_origin_next    = real_origin_reg;
        virtual_origin_next = virtual_origin_reg;
        rate_next           = rate_reg;
        run_state_next      = run_state_reg;
        frozen_time_next    = frozen_time_reg;
        out_valid_next      = out_valid_reg && out_stall;
        time_out_next       = time_out_reg;
        rate_out_next       = rate_out_reg;
        run_state_out_next  = run_state_out_reg;
        error_code_next     = error_code_reg;

        if (cfg_valid)
        begin
            time_limit_next = cfg_data;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = need_calc ? T_LAUNCH : T_FINISH;
                end
            end
            T_LAUNCH:
            begin
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (eng_res.done)
                begin
                    state_next = T_FINISH;
                end
            end
            T_FINISH:
            begin
                if (commit)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        if (commit)
        begin
            // failed or refused commands leave the clock state alone
            time_out_next   = '0;
            error_code_next = rcvc_pkg::ERR_OK;
            case (func_reg)
                rcvc_pkg::FUNC_READ:
                begin
                    if (run_state_reg != rcvc_pkg::ST_RUNNING)
                    begin
                        time_out_next = frozen_time_reg;
                    end
                    else if (calc_fail_reg)
                    begin
                        error_code_next = rcvc_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        time_out_next = calc_time_reg;
                    end
                end
                rcvc_pkg::FUNC_SET_TIME:
                begin
                    real_origin_next    = now_reg;
                    virtual_origin_next = newt_reg;
                    frozen_time_next    = newt_reg;
                    time_out_next       = newt_reg;
                end
                rcvc_pkg::FUNC_SET_RATE:
                begin
                    if (calc_fail_reg)
                    begin
                        error_code_next = rcvc_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        real_origin_next    = now_reg;
                        virtual_origin_next = calc_time_reg;
                        rate_next           = newr_reg;
                        time_out_next       = calc_time_reg;
                    end
                end
                rcvc_pkg::FUNC_PAUSE:
                begin
                    if (run_state_reg != rcvc_pkg::ST_RUNNING)
                    begin
                        error_code_next = rcvc_pkg::ERR_ORDER;
                    end
                    else if (calc_fail_reg)
                    begin
                        error_code_next = rcvc_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        frozen_time_next = calc_time_reg;
                        run_state_next   = rcvc_pkg::ST_PAUSED;
                        time_out_next    = calc_time_reg;
                    end
                end
                rcvc_pkg::FUNC_RESUME:
                begin
                    if (run_state_reg != rcvc_pkg::ST_PAUSED)
                    begin
                        error_code_next = rcvc_pkg::ERR_ORDER;
                    end
                    else
                    begin
                        // restart from the frozen point at the current real time
                        run_state_next      = rcvc_pkg::ST_RUNNING;
                        real_origin_next    = now_reg;
                        virtual_origin_next = frozen_time_reg;
                        frozen_time_next    = '0;
                        time_out_next       = frozen_time_reg;
                    end
                end
                rcvc_pkg::FUNC_TERMINATE:
                begin
                    run_state_next = rcvc_pkg::ST_STOPPED;
                    time_out_next  = frozen_time_reg;
                end
                default:
                begin
                    // unused codes: report the state unchanged
                    time_out_next = '0;
                end
            endcase
            rate_out_next      = rate_next;
            run_state_out_next = run_state_next;
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= T_IDLE;
            time_limit_reg     <= '1;
            real_origin_reg    <= '0;
            virtual_origin_reg <= '0;
            rate_reg           <= RW'(RATE_SCALE);
            run_state_reg      <= rcvc_pkg::ST_RUNNING;
            frozen_time_reg    <= '0;
            out_valid_reg      <= 1'b0;
            time_out_reg       <= '0;
            rate_out_reg       <= '0;
            run_state_out_reg  <= rcvc_pkg::ST_RUNNING;
            error_code_reg     <= rcvc_pkg::ERR_OK;
        end
        else
        begin
            state_reg          <= state_next;
            time_limit_reg     <= time_limit_next;
            real_origin_reg    <= real_origin_next;
            virtual_origin_reg <= virtual_origin_next;
            rate_reg           <= rate_next;
            run_state_reg      <= run_state_next;
            frozen_time_reg    <= frozen_time_next;
            out_valid_reg      <= out_valid_next;
            time_out_reg       <= time_out_next;
            rate_out_reg       <= rate_out_next;
            run_state_out_reg  <= run_state_out_next;
            error_code_reg     <= error_code_next;
        end
    end

    // hold the request operands and the engine answer for the commit
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            now_reg  <= real_now;
            newt_reg <= new_time;
            newr_reg <= new_rate;
        end
        if (eng_res.done)
        begin
            calc_fail_reg <= eng_res.fail;
            calc_time_reg <= eng_res.vtime;
        end
    end

    assign out_valid     = out_valid_reg;
    assign time_out      = time_out_reg;
    assign rate_out      = rate_out_reg;
    assign run_state_out = run_state_out_reg;
    assign error_code    = error_code_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) eng_res.done |-> state_reg == T_WAIT)
        else $error("engine answer arrived with no computation pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != rcvc_pkg::ERR_OK) |-> time_out == '0)
        else $error("error result carries a nonzero time");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_state_reg == rcvc_pkg::ST_RUNNING || run_state_reg == rcvc_pkg::ST_PAUSED
        || run_state_reg == rcvc_pkg::ST_STOPPED)
        else $error("run state holds an unused code");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == T_LAUNCH || state_reg == T_FINISH))
        else $error("accepted request was not taken into work");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench of the rate-controlled virtual clock
// Drives command requests with bursty timing against a randomly stalling
// result receiver, predicts every reply with a cycle-free mirror of the clock
// (origins, rate, run state, frozen time, time limit) and compares each reply
// field by field. Directed checks come first, then randomized traffic under
// several time limits, and last the stopped state, since nothing leaves it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import rcvc_pkg::*;

    localparam int HALF_PERIOD_NS  = 2;        // 4 ns clock
    localparam int RESET_CYCLES    = 3;
    localparam int SCALE           = RATE_SCALE_DEFAULT;
    // the slowest request runs the full divide and multiply; allow long sender gaps and stalls on top
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int END_HOLD        = 150;
    localparam int PHASE_REQUESTS  = 270;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    localparam logic [TIME_W-1:0]        TIME_MAX = '1;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_ONE = SCALE;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    typedef struct packed {
        logic [TIME_W-1:0]        vtime;
        logic signed [RATE_W-1:0] rate;
        logic [STATE_W-1:0]       run_st;
        logic [ERR_W-1:0]         err;
    } clock_reply_t;

    // ------------------------------------------------------------------------
    // clock, reset and DUT
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [FUNC_W-1:0]           func      = '0;
    logic [TIME_W-1:0]           real_now  = '0;
    logic [TIME_W-1:0]           new_time  = '0;
    logic signed [RATE_W-1:0]    new_rate  = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [TIME_W-1:0]           time_out;
    logic signed [RATE_W-1:0]    rate_out;
    logic [STATE_W-1:0]          run_state_out;
    logic [ERR_W-1:0]            error_code;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [TIME_W-1:0]           cfg_data  = '0;

    always #(HALF_PERIOD_NS) clk = ~clk;

    rate_controlled_virtual_clock #(
        .RATE_SCALE (SCALE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .real_now      (real_now),
        .new_time      (new_time),
        .new_rate      (new_rate),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .time_out      (time_out),
        .rate_out      (rate_out),
        .run_state_out (run_state_out),
        .error_code    (error_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // mirror of the clock state, starting from its reset values
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]        limit_reg      = '1;
    logic [TIME_W-1:0]        anchor_real    = '0;
    logic [TIME_W-1:0]        anchor_virtual = '0;
    logic signed [RATE_W-1:0] cur_rate       = RATE_ONE;
    logic [STATE_W-1:0]       cur_run        = ST_RUNNING;
    logic [TIME_W-1:0]        held_time      = '0;

    clock_reply_t reply_q[$];
    int           failures = 0;

    // latest real time handed out; random requests mostly move forward from it
    logic [TIME_W-1:0] wall_clock = '0;

    // Virtual time at real time t. Return 0 on overflow past the limit or
    // underflow below zero; the range tests are exact 128-bit products.
    function automatic bit virtual_time_at(input logic [TIME_W-1:0] t,
                                           output logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] room;
        logic [TIME_W-1:0] mag;
        logic [TIME_W-1:0] rate_wide;
        logic [TIME_W-1:0] scale_wide;
        logic [127:0]      scale_prod;
        logic [127:0]      lhs;
        logic [127:0]      rhs;
        delta      = t - anchor_real;
        rate_wide  = {{(TIME_W-RATE_W){cur_rate[RATE_W-1]}}, cur_rate};
        scale_wide = TIME_W'(SCALE);
        scale_prod = 128'(SCALE);
        v          = '0;
        if (!cur_rate[RATE_W-1])
        begin
            room = limit_reg - anchor_virtual;
            if (delta > room)
                return 1'b0;
            // rate one bypasses the divide and multiply
            if (cur_rate == RATE_ONE)
            begin
                v = anchor_virtual + delta;
                return 1'b1;
            end
            lhs = {64'd0, room} * scale_prod;
            rhs = {64'd0, rate_wide} * {64'd0, delta};
            if (delta != 0 && lhs < rhs)
                return 1'b0;
        end
        else
        begin
            mag = 64'd0 - rate_wide;
            if (delta > anchor_virtual)
                return 1'b0;
            lhs = {64'd0, anchor_virtual} * scale_prod;
            rhs = {64'd0, mag} * {64'd0, delta};
            if (delta != 0 && lhs < rhs)
                return 1'b0;
        end
        v = anchor_virtual + (delta / scale_wide) * rate_wide;
        return 1'b1;
    endfunction

    // Apply one command to the mirror and return the reply it must produce.
    function automatic clock_reply_t apply_command(input logic [FUNC_W-1:0] f,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] set_to,
                                                   input logic signed [RATE_W-1:0] rate_in);
        clock_reply_t      r;
        logic [TIME_W-1:0] v;
        r.vtime = '0;
        r.err   = ERR_OK;
        case (f)
            FUNC_READ:
            begin
                if (cur_run != ST_RUNNING)
                    r.vtime = held_time;
                else if (virtual_time_at(now, v))
                    r.vtime = v;
                else
                    r.err = ERR_RANGE;
            end
            FUNC_SET_TIME:
            begin
                anchor_real    = now;
                anchor_virtual = set_to;
                held_time      = set_to;
                r.vtime        = set_to;
            end
            FUNC_SET_RATE:
            begin
                // computed from the origins even while paused or stopped
                if (virtual_time_at(now, v))
                begin
                    anchor_real    = now;
                    anchor_virtual = v;
                    cur_rate       = rate_in;
                    r.vtime        = v;
                end
                else
                begin
                    r.err = ERR_RANGE;
                end
            end
            FUNC_PAUSE:
            begin
                if (cur_run != ST_RUNNING)
                begin
                    r.err = ERR_ORDER;
                end
                else if (virtual_time_at(now, v))
                begin
                    held_time = v;
                    cur_run   = ST_PAUSED;
                    r.vtime   = v;
                end
                else
                begin
                    r.err = ERR_RANGE;
                end
            end
            FUNC_RESUME:
            begin
                if (cur_run != ST_PAUSED)
                begin
                    r.err = ERR_ORDER;
                end
                else
                begin
                    cur_run        = ST_RUNNING;
                    anchor_real    = now;
                    anchor_virtual = held_time;
                    held_time      = '0;
                    r.vtime        = anchor_virtual;
                end
            end
            FUNC_TERMINATE:
            begin
                cur_run = ST_STOPPED;
                r.vtime = held_time;
            end
            default: ;  // unused codes: no state change
        endcase
        r.rate   = cur_rate;
        r.run_st = cur_run;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side: bursts of back-to-back requests separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_command(input logic [FUNC_W-1:0] f,
                                input logic [TIME_W-1:0] now,
                                input logic [TIME_W-1:0] set_to,
                                input logic signed [RATE_W-1:0] rate_in);
        int gap;
        func     <= f;
        real_now <= now;
        new_time <= set_to;
        new_rate <= rate_in;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        reply_q.push_back(apply_command(f, now, set_to, rate_in));
        // close the burst with a gap; long gaps land inside the slow divide
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                               : $urandom_range(9, 160);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Hold off new requests until every outstanding reply has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the time limit; only called with the clock idle.
    task automatic write_time_limit(input logic [TIME_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        limit_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random field generators
    // ------------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] pick_real_now();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            wall_clock = wall_clock + $urandom_range(0, 3000);
        else if (p < 80)
            wall_clock = wall_clock + ({$urandom, $urandom} >> $urandom_range(20, 63));
        else if (p < 90)
            return wall_clock - $urandom_range(1, 5000);    // behind the origin: wraps
        else
            wall_clock = {$urandom, $urandom};
        return wall_clock;
    endfunction

    function automatic logic [TIME_W-1:0] pick_new_time();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return {32'd0, $urandom};
        else if (p < 60)
            return {$urandom, $urandom};
        else if (p < 75)
            return limit_reg - $urandom_range(0, 100000);   // just under the limit
        else if (p < 85)
            return TIME_W'($urandom_range(0, 1000));
        else if (p < 92)
            return TIME_MAX;
        return 64'd1 << $urandom_range(0, 63);
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_new_rate();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30)
            return RATE_ONE;
        else if (p < 45)
            return '0;
        else if (p < 65)
            return $urandom_range(1, 5000);
        else if (p < 85)
            return -int'($urandom_range(1, 5000));
        else if (p < 95)
            return $urandom;
        return $urandom_range(0, 1) ? RATE_MIN : RATE_MAX;
    endfunction

    // Mostly well-formed traffic with random content; a few unused codes as
    // noise. Terminate only when the stopped state is wanted.
    task automatic run_random_commands(input int count, input bit allow_stop);
        int                sent;
        int                pick;
        logic [FUNC_W-1:0] f;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 33)
                f = FUNC_READ;
            else if (pick < 45)
                f = FUNC_SET_TIME;
            else if (pick < 63)
                f = FUNC_SET_RATE;
            else if (pick < 76)
                f = FUNC_PAUSE;
            else if (pick < 89)
                f = FUNC_RESUME;
            else if (pick < 93 && allow_stop)
                f = FUNC_TERMINATE;
            else if (pick < 96)
                f = $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
            else
                f = FUNC_READ;
            send_command(f, pick_real_now(), pick_new_time(), pick_new_rate());
            if (f <= FUNC_TERMINATE)
                sent++;
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // Extremes of real and virtual time, overflow, underflow and rate paths.
    task automatic test_timekeeping();
        send_command(FUNC_READ, 64'd0, {$urandom, $urandom}, $urandom);
        send_command(FUNC_READ, TIME_MAX, {$urandom, $urandom}, $urandom);
        send_command(FUNC_SET_TIME, 64'd5, TIME_MAX, $urandom);
        send_command(FUNC_READ, 64'd6, '0, '0);                 // one past the limit
        send_command(FUNC_SET_RATE, 64'd6, '0, 32'sd7);         // fails, rate kept
        send_command(FUNC_SET_TIME, 64'd100, 64'd0, RATE_MAX);
        send_command(FUNC_SET_RATE, 64'd100, TIME_MAX, RATE_MIN);
        send_command(FUNC_READ, 64'd100, '0, '0);
        send_command(FUNC_READ, 64'd2100, '0, '0);              // below zero
        send_command(FUNC_SET_TIME, 64'd0, 64'd1_000_000_000_000, '0);
        send_command(FUNC_SET_RATE, 64'd0, '0, RATE_MAX);
        send_command(FUNC_READ, 64'd5000, '0, '0);
        send_command(FUNC_SET_RATE, 64'd5999, '0, 32'sd0);      // truncating divide
        send_command(FUNC_READ, TIME_MAX, '0, '0);
        send_command(FUNC_SET_RATE, 64'd6000, '0, -32'sd1);
    endtask

    // Pause and resume ordering, set rate and set time while paused.
    task automatic test_run_state_order();
        send_command(FUNC_PAUSE, 64'd7000, '0, '0);
        send_command(FUNC_PAUSE, 64'd7001, '0, '0);             // not running
        send_command(FUNC_READ, 64'd9000, '0, '0);
        send_command(FUNC_SET_RATE, 64'd9000, '0, RATE_ONE);
        send_command(FUNC_SET_TIME, 64'd9100, 64'h5555_AAAA_5555_AAAA, '0);
        send_command(FUNC_RESUME, 64'd9200, '0, '0);
        send_command(FUNC_RESUME, 64'd9300, '0, '0);            // not paused
        wall_clock = 64'd9300;
    endtask

    // Unused command codes leave the state alone.
    task automatic test_unused_codes();
        send_command(FUNC_UNUSED_LO, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        send_command(FUNC_UNUSED_HI, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    endtask

    // Random traffic under a sequence of time limits, extremes included.
    task automatic test_random_traffic();
        logic [TIME_W-1:0] limits [6];
        limits[0] = TIME_MAX;
        limits[1] = 64'd0;
        limits[2] = {$urandom, $urandom};
        limits[3] = 64'd1_000_000 + $urandom_range(0, 1_000_000);
        limits[4] = 64'h8000_0000_0000_0000;
        limits[5] = TIME_MAX;
        foreach (limits[i])
        begin
            hold_until_drained();
            write_time_limit(limits[i]);
            run_random_commands(PHASE_REQUESTS, 1'b0);
        end
    endtask

    // Stopped absorbs everything that follows, so run it last.
    task automatic test_stopped_clock();
        send_command(FUNC_TERMINATE, pick_real_now(), '0, '0);
        send_command(FUNC_TERMINATE, pick_real_now(), '0, '0);
        send_command(FUNC_PAUSE, pick_real_now(), '0, '0);
        send_command(FUNC_RESUME, pick_real_now(), '0, '0);
        run_random_commands(60, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // result receiver: stall pattern switches between free flow, light and
    // heavy random stalls, and a fixed duty cycle
    // ------------------------------------------------------------------------
    flow_mode_t flow_mode = FLOW_FREE;
    int         flow_left = 0;

    always @(posedge clk)
    begin
        if (flow_left == 0)
        begin
            flow_mode <= flow_mode_t'($urandom_range(0, 3));
            flow_left <= $urandom_range(30, 400);
        end
        else
        begin
            flow_left <= flow_left - 1;
        end
        case (flow_mode)
            FLOW_FREE:  out_stall <= 1'b0;
            FLOW_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            FLOW_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
            default:    out_stall <= ((flow_left % 9) < 4);
        endcase
    end

    function automatic void check_field(input string name,
                                        input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            failures = failures + 1;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Compare each accepted reply with the oldest prediction.
    always @(posedge clk)
    begin : reply_check
        clock_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                failures = failures + 1;
                $error("reply with no request waiting: time_out %0h", time_out);
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("time_out", want.vtime, time_out);
                check_field("rate_out", {32'd0, want.rate}, {32'd0, rate_out});
                check_field("run_state_out", {62'd0, want.run_st}, {62'd0, run_state_out});
                check_field("error_code", {62'd0, want.err}, {62'd0, error_code});
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: end the run when no handshake completes for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rate_controlled_virtual_clock");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_timekeeping();
        test_run_state_order();
        test_unused_codes();
        test_random_traffic();
        test_stopped_clock();

        // drain, then give the block time to show any stray reply
        hold_until_drained();
        repeat (END_HOLD) @(posedge clk);
        if (failures == 0)
            $display("PASS rate_controlled_virtual_clock");
        else
            $display("FAIL rate_controlled_virtual_clock");
        $finish;
    end

endmodule

>>> sim.f
sv/rcvc_pkg.sv
sv/rcvc_engine.sv
sv/rate_controlled_virtual_clock.sv
bench/testbench.sv
